// ===== sv/fbc_pkg.sv =====
`timescale 1ns / 1ps
// fbc_pkg: shared types, constants and round functions for the 64-bit Feistel cipher.
// No dependencies; used by every module of the cipher.
package fbc_pkg;

    localparam int unsigned ROUNDS = 8;
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCW = $clog2(QDEPTH + 1);

    localparam logic [63:0] KEY_RESET = 64'h96E2_43A6_7D7B_CFB1;
    localparam int unsigned F_ROTL = 9;
    localparam int unsigned K_ROTR = 11;

    typedef enum logic
    {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic        decrypt;
        logic [31:0] left;
        logic [31:0] right;
    } item_t;

    function automatic logic [31:0] round_key(input logic [63:0] key, input int unsigned idx);
        logic [5:0]   sh;
        logic [127:0] dbl;
        sh  = 6'((idx << 3) & 63);
        dbl = {key, key} >> sh;
        return dbl[31:0];
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [31:0] key);
        logic [31:0] mixed;
        logic [31:0] rot;
        mixed = ((key >> K_ROTR) | (key << (32 - K_ROTR))) | half;
        rot   = (half << F_ROTL) | (half >> (32 - F_ROTL));
        return rot ^ {31'd0, (mixed == 32'd0)};
    endfunction

endpackage

// ===== sv/fbc_front.sv =====
`timescale 1ns / 1ps
// fbc_front: input stage; takes a block and command, splits halves, decodes direction.
// Depends on fbc_pkg.
module fbc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [63:0]         block_in,
    output logic                item_valid,
    input  logic                item_ready,
    output fbc_pkg::item_t      item
);
    import fbc_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign in_ready   = !vld_reg || item_ready;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (item_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.decrypt <= (cmd_t'(cmd) == CMD_DECRYPT);
            item_reg.left    <= block_in[63:32];
            item_reg.right   <= block_in[31:0];
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> vld_reg)
        else $error("front stalled with empty stage");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg)
        else $error("transfer into front lost");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && !item_ready |=> vld_reg && $stable(item_reg))
        else $error("front item changed while stalled");

endmodule

// ===== sv/fbc_queue.sv =====
`timescale 1ns / 1ps
// fbc_queue: short FIFO between front and round pipeline.
// Depends on fbc_pkg (item_t, QDEPTH).
module fbc_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  fbc_pkg::item_t      push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output fbc_pkg::item_t      pop_item
);
    import fbc_pkg::*;

    item_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != QCW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("queue count overflow");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCW'(QDEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push not counted");

endmodule

// ===== sv/fbc_back.sv =====
`timescale 1ns / 1ps
// fbc_back: round pipeline, one Feistel round per stage; last stage is the output register.
// Depends on fbc_pkg (item_t, round_key, round_fn, ROUNDS).
module fbc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         key,
    input  logic                item_valid,
    output logic                item_ready,
    input  fbc_pkg::item_t      item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         block_out
);
    import fbc_pkg::*;

    logic [ROUNDS-1:0] v_reg;
    logic [ROUNDS-1:0] v_next;
    item_t             st_reg [ROUNDS];
    item_t             st_next [ROUNDS];
    logic              en;

    assign en         = !v_reg[ROUNDS-1] || out_ready;
    assign item_ready = en;
    assign out_valid  = v_reg[ROUNDS-1];
    assign block_out  = {st_reg[ROUNDS-1].left, st_reg[ROUNDS-1].right};

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        item_t       src;
        logic [31:0] k;
        logic [31:0] mixed;

        if (i == 0)
        begin : g_head
            assign src       = item;
            assign v_next[i] = item_valid;
        end
        else
        begin : g_body
            assign src       = st_reg[i-1];
            assign v_next[i] = v_reg[i-1];
        end

        assign k     = src.decrypt ? round_key(key, ROUNDS - 1 - i) : round_key(key, i);
        assign mixed = src.right ^ round_fn(src.left, k);

        if (i < ROUNDS - 1)
        begin : g_swap
            assign st_next[i] = '{decrypt: src.decrypt, left: mixed, right: src.left};
        end
        else
        begin : g_last
            assign st_next[i] = '{decrypt: src.decrypt, left: src.left, right: mixed};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && item_valid |=> v_reg[0])
        else $error("accepted item missing from first round");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_out))
        else $error("result changed while stalled");

endmodule

// ===== sv/feistel_block_cipher_64.sv =====
`timescale 1ns / 1ps
// feistel_block_cipher_64: top level of the 8-round 64-bit Feistel cipher.
// Depends on fbc_pkg, fbc_front, fbc_queue, fbc_back.
//
//  channel   signals                           direction
//  input     in_valid/in_ready, cmd, block_in  in
//  output    out_valid/out_ready, block_out    out
//  config    cfg_valid/cfg_ready, cfg_data     in
//
// One block per cycle sustained without output stalls; blocks pass the front
// stage, queue and one pipeline stage per round. The key register resets to
// KEY_RESET and config is always ready. A stall at the output freezes the
// round pipeline; the queue then fills and the front stalls after it.
module feistel_block_cipher_64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [63:0] block_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] block_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import fbc_pkg::*;

    logic [63:0] key_reg;
    logic        f_valid;
    logic        f_ready;
    item_t       f_item;
    logic        q_valid;
    logic        q_ready;
    item_t       q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cfg_data;
        end
    end

    fbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .block_in   (block_in),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    fbc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    fbc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .block_out  (block_out)
    );

endmodule
